// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file hilo_rtu_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hilo_rtu_pkg.sv =====
package hilo_rtu_pkg;

  // action codes
  localparam logic [4:0] ACT_MFHI      = 5'd0;
  localparam logic [4:0] ACT_MFLO      = 5'd1;
  localparam logic [4:0] ACT_MOVN      = 5'd2;
  localparam logic [4:0] ACT_MOVZ      = 5'd3;
  localparam logic [4:0] ACT_MTHI      = 5'd4;
  localparam logic [4:0] ACT_MTLO      = 5'd5;
  localparam logic [4:0] ACT_MFHI1     = 5'd6;
  localparam logic [4:0] ACT_MFLO1     = 5'd7;
  localparam logic [4:0] ACT_MTHI1     = 5'd8;
  localparam logic [4:0] ACT_MTLO1     = 5'd9;
  localparam logic [4:0] ACT_PMFHI     = 5'd10;
  localparam logic [4:0] ACT_PMFLO     = 5'd11;
  localparam logic [4:0] ACT_PMTHI     = 5'd12;
  localparam logic [4:0] ACT_PMTLO     = 5'd13;
  localparam logic [4:0] ACT_PMTHL_LW  = 5'd14;
  localparam logic [4:0] ACT_PMFHL_LW  = 5'd15;
  localparam logic [4:0] ACT_PMFHL_UW  = 5'd16;
  localparam logic [4:0] ACT_PMFHL_SLW = 5'd17;
  localparam logic [4:0] ACT_PMFHL_LH  = 5'd18;
  localparam logic [4:0] ACT_PMFHL_SH  = 5'd19;

  localparam logic [63:0] WORD_MAX  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] WORD_MIN  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [15:0] HWORD_MAX = 16'h7FFF;
  localparam logic [15:0] HWORD_MIN = 16'h8000;

  // per-word write request into hi/lo
  typedef struct packed {
    logic [3:0]   hi_we;
    logic [127:0] hi_d;
    logic [3:0]   lo_we;
    logic [127:0] lo_d;
  } hilo_wr_t;

  // destination result, values already zero where not written
  typedef struct packed {
    logic         wl;
    logic         wh;
    logic [127:0] val;
  } hilo_res_t;

  // signed 64 -> signed 32, sign-extended back to 64
  function automatic logic [63:0] sat_word(input logic [63:0] x);
    logic [63:0] r;
    r = x;
    if (!((&x[63:31]) || !(|x[63:31]))) begin
      r = x[63] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

  // signed 32 -> signed 16
  function automatic logic [15:0] sat_hword(input logic [31:0] w);
    logic [15:0] r;
    r = w[15:0];
    if (!((&w[31:15]) || !(|w[31:15]))) begin
      r = w[31] ? HWORD_MIN : HWORD_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hilo_rtu_if.sv =====
interface hilo_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  action;
  logic [4:0]  dest_index;
  logic [63:0] source_low;
  logic [63:0] source_high;
  logic [63:0] condition_low;

  modport source (output valid, action, dest_index, source_low, source_high,
                  condition_low, input ready);
  modport sink   (input valid, action, dest_index, source_low, source_high,
                  condition_low, output ready);
endinterface

interface hilo_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dest_number;
  logic        write_low;
  logic        write_high;
  logic [63:0] value_low;
  logic [63:0] value_high;

  modport source (output valid, dest_number, write_low, write_high, value_low,
                  value_high, input ready);
  modport sink   (input valid, dest_number, write_low, write_high, value_low,
                  value_high, output ready);
endinterface

// ===== hw/rtl/hilo_register_transfer_unit.sv =====
// channel  modport  moves
// in_ch    sink     one request: action, dest_index, source dwords, condition dword
// out_ch   source   one result: dest_number, write enables, destination dwords
//
// one request per cycle sustained while out_ch.ready holds; a request passes
// the input register and then the result register around the execute logic
// hi/lo are updated as a request leaves the input register, so the next
// request always sees them; rst_n (synchronous) clears hi/lo and both valids
// a stalled result holds its register; the input register still takes a
// request while empty, so at most one request waits behind a stalled result
module hilo_register_transfer_unit (
  input  logic        clk,
  input  logic        rst_n,
  hilo_in_if.sink     in_ch,
  hilo_out_if.source  out_ch
);
  import hilo_rtu_pkg::*;

  // input register
  logic         s1_valid_r, s1_valid_nxt;
  logic [4:0]   s1_action_r;
  logic [4:0]   s1_dest_r;
  logic [127:0] s1_src_r;
  logic [63:0]  s1_cond_r;

  // result register
  logic         out_valid_r, out_valid_nxt;
  logic [4:0]   out_dest_r;
  hilo_res_t    out_res_r;

  logic         s1_adv;
  logic         in_take;
  logic [127:0] hi_q, lo_q;
  hilo_wr_t     wr;
  hilo_res_t    res;

  // the request in the input register moves on when the result slot is free
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_ch.action;
      s1_dest_r   <= in_ch.dest_index;
      s1_src_r    <= {in_ch.source_high, in_ch.source_low};
      s1_cond_r   <= in_ch.condition_low;
    end
    if (s1_adv) begin
      out_dest_r <= s1_dest_r;
      out_res_r  <= res;
    end
  end

  hilo_rtu_exec u_exec (
    .action (s1_action_r),
    .src    (s1_src_r),
    .cond   (s1_cond_r),
    .hi     (hi_q),
    .lo     (lo_q),
    .wr     (wr),
    .res    (res)
  );

  // hi/lo commit only when the request actually leaves the input register
  hilo_rtu_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (s1_adv),
    .wr    (wr),
    .hi_q  (hi_q),
    .lo_q  (lo_q)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.dest_number = out_dest_r;
  assign out_ch.write_low   = out_res_r.wl;
  assign out_ch.write_high  = out_res_r.wh;
  assign out_ch.value_low   = out_res_r.val[63:0];
  assign out_ch.value_high  = out_res_r.val[127:64];

endmodule

// ===== hw/rtl/hilo_rtu_regs.sv =====
module hilo_rtu_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  hilo_rtu_pkg::hilo_wr_t wr,
  output logic [127:0]          hi_q,
  output logic [127:0]          lo_q
);
  import hilo_rtu_pkg::*;

  logic [127:0] hi_r, hi_nxt;
  logic [127:0] lo_r, lo_nxt;

  // word-granular merge
  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    for (int k = 0; k < 4; k++) begin
      if (wr_en && wr.hi_we[k]) begin
        hi_nxt[32*k +: 32] = wr.hi_d[32*k +: 32];
      end
      if (wr_en && wr.lo_we[k]) begin
        lo_nxt[32*k +: 32] = wr.lo_d[32*k +: 32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign hi_q = hi_r;
  assign lo_q = lo_r;

endmodule

// ===== hw/rtl/hilo_rtu_exec.sv =====
module hilo_rtu_exec (
  input  logic [4:0]             action,
  input  logic [127:0]           src,
  input  logic [63:0]            cond,
  input  logic [127:0]           hi,
  input  logic [127:0]           lo,
  output hilo_rtu_pkg::hilo_wr_t  wr,
  output hilo_rtu_pkg::hilo_res_t res
);
  import hilo_rtu_pkg::*;

  always_comb begin
    wr.hi_we = 4'b0000;
    wr.lo_we = 4'b0000;
    wr.hi_d  = src;
    wr.lo_d  = src;
    res.wl   = 1'b0;
    res.wh   = 1'b0;
    res.val  = '0;
    case (action)
      ACT_MFHI: begin
        res.val[63:0] = hi[63:0];
        res.wl        = 1'b1;
      end
      ACT_MFLO: begin
        res.val[63:0] = lo[63:0];
        res.wl        = 1'b1;
      end
      ACT_MOVN: begin
        if (cond != 64'd0) begin
          res.val[63:0] = src[63:0];
          res.wl        = 1'b1;
        end
      end
      ACT_MOVZ: begin
        if (cond == 64'd0) begin
          res.val[63:0] = src[63:0];
          res.wl        = 1'b1;
        end
      end
      ACT_MTHI: wr.hi_we = 4'b0011;
      ACT_MTLO: wr.lo_we = 4'b0011;
      ACT_MFHI1: begin
        res.val[63:0] = hi[127:64];
        res.wl        = 1'b1;
      end
      ACT_MFLO1: begin
        res.val[63:0] = lo[127:64];
        res.wl        = 1'b1;
      end
      ACT_MTHI1: begin
        wr.hi_we = 4'b1100;
        wr.hi_d  = {src[63:0], src[63:0]};
      end
      ACT_MTLO1: begin
        wr.lo_we = 4'b1100;
        wr.lo_d  = {src[63:0], src[63:0]};
      end
      ACT_PMFHI: begin
        res.val = hi;
        res.wl  = 1'b1;
        res.wh  = 1'b1;
      end
      ACT_PMFLO: begin
        res.val = lo;
        res.wl  = 1'b1;
        res.wh  = 1'b1;
      end
      ACT_PMTHI: wr.hi_we = 4'b1111;
      ACT_PMTLO: wr.lo_we = 4'b1111;
      ACT_PMTHL_LW: begin
        // even source words to lo, odd ones to hi, only even words written
        wr.lo_we = 4'b0101;
        wr.hi_we = 4'b0101;
        wr.lo_d  = {32'd0, src[95:64], 32'd0, src[31:0]};
        wr.hi_d  = {32'd0, src[127:96], 32'd0, src[63:32]};
      end
      ACT_PMFHL_LW: begin
        res.val = {hi[95:64], lo[95:64], hi[31:0], lo[31:0]};
        res.wl  = 1'b1;
        res.wh  = 1'b1;
      end
      ACT_PMFHL_UW: begin
        res.val = {hi[127:96], lo[127:96], hi[63:32], lo[63:32]};
        res.wl  = 1'b1;
        res.wh  = 1'b1;
      end
      ACT_PMFHL_SLW: begin
        res.val[63:0]   = sat_word({hi[31:0], lo[31:0]});
        res.val[127:64] = sat_word({hi[95:64], lo[95:64]});
        res.wl          = 1'b1;
        res.wh          = 1'b1;
      end
      ACT_PMFHL_LH: begin
        for (int i = 0; i < 2; i++) begin
          res.val[64*i +: 16]      = lo[64*i +: 16];
          res.val[64*i + 16 +: 16] = lo[64*i + 32 +: 16];
          res.val[64*i + 32 +: 16] = hi[64*i +: 16];
          res.val[64*i + 48 +: 16] = hi[64*i + 32 +: 16];
        end
        res.wl = 1'b1;
        res.wh = 1'b1;
      end
      ACT_PMFHL_SH: begin
        for (int i = 0; i < 2; i++) begin
          res.val[64*i +: 16]      = sat_hword(lo[64*i +: 32]);
          res.val[64*i + 16 +: 16] = sat_hword(lo[64*i + 32 +: 32]);
          res.val[64*i + 32 +: 16] = sat_hword(hi[64*i +: 32]);
          res.val[64*i + 48 +: 16] = sat_hword(hi[64*i + 32 +: 32]);
        end
        res.wl = 1'b1;
        res.wh = 1'b1;
      end
      default: begin
        // unused codes: no write anywhere
        res.wl = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hilo_rtu_checker.sv =====
`include "assert_macros.svh"

module hilo_rtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_low,
  input logic        out_write_high,
  input logic [63:0] out_value_low,
  input logic [63:0] out_value_high
);

  // a result waiting for the sink stays offered
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid,
    "result dropped while stalled")

  // high dword is never written without the low one
  `ASSERT_CLKD(a_wh_wl, clk, rst_n, out_valid && out_write_high |-> out_write_low,
    "high write without low write")

  // unwritten dwords read as zero
  `ASSERT_CLKD(a_zero_val, clk, rst_n,
    out_valid |-> (out_write_low || out_value_low == 64'd0) &&
                  (out_write_high || out_value_high == 64'd0),
    "nonzero value on unwritten dword")

  // nothing offered in the cycle after reset
  `ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

  // with the result slot empty the input register can always move on
  `ASSERT_CLKD(a_ready_free, clk, rst_n, !out_valid |-> in_ready,
    "input stalled with free output")

endmodule

bind hilo_register_transfer_unit hilo_rtu_checker u_hilo_rtu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_write_low  (out_ch.write_low),
  .out_write_high (out_ch.write_high),
  .out_value_low  (out_ch.value_low),
  .out_value_high (out_ch.value_high)
);
